// File: sv/periodic_timer_table_core_macros.svh
// Assertion macros for the periodic timer table.
// Both expect a clock named clk and a synchronous active high reset named rst.
`ifndef PERIODIC_TIMER_TABLE_CORE_MACROS_SVH
`define PERIODIC_TIMER_TABLE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold in the same cycle as the condition.
`define PTT_ASSERT_NOW(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("timer table check failed");

// The property must hold in the cycle after the condition.
`define PTT_ASSERT_NEXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("timer table check failed");

`else

`define PTT_ASSERT_NOW(name, cond, prop)
`define PTT_ASSERT_NEXT(name, cond, prop)

`endif

`endif

// File: sv/ptt_pkg.sv
package ptt_pkg;

  // Command codes.
  localparam logic [1:0] ACT_START   = 2'd0;
  localparam logic [1:0] ACT_CANCEL  = 2'd1;
  localparam logic [1:0] ACT_ADVANCE = 2'd2;
  localparam logic [1:0] ACT_CLEAR   = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_ZERO_STEP = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] interval_ticks;
    logic [15:0] repeat_count;
    logic [31:0] cancel_handle;
    logic [31:0] step_ticks;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] new_handle;
    logic        fired_valid;
    logic [31:0] fired_handle;
    logic [4:0]  fired_in_step;
    logic [4:0]  active_count;
    logic [31:0] total_fired;
    logic        last;
  } res_t;

  // One timer entry as held in the slot memory.
  typedef struct packed {
    logic [31:0]        handle;
    logic [31:0]        interval;
    logic signed [33:0] remaining;
    logic [15:0]        repeats;
  } slot_t;

  // Outcome of one pass of the slot update unit.
  typedef struct packed {
    logic  fire;
    logic  keep;
    slot_t slot;
  } upd_t;

endpackage

// File: sv/ptt_slot_unit.sv
module ptt_slot_unit (
  input  logic            clk,
  input  logic            load,
  input  logic            advance,
  input  ptt_pkg::slot_t  slot,
  input  logic [31:0]     step,
  output ptt_pkg::upd_t   upd
);

  // The first stage subtracts the step; the second decides the fire and rearms.
  ptt_pkg::slot_t     cur;
  logic               cur_adv;
  logic signed [34:0] rem1;
  logic signed [34:0] rem_once;
  logic signed [34:0] rem_twice;
  logic [15:0]        rep_dec;
  logic               due;

  always_ff @(posedge clk) begin
    if (load) begin
      cur     <= slot;
      cur_adv <= advance;
      rem1    <= {slot.remaining[33], slot.remaining} - {3'b000, step};
    end
  end

  always_comb begin
    rem_once  = rem1 + $signed({3'b000, cur.interval});
    rem_twice = rem1 + $signed({2'b00, cur.interval, 1'b0});
    rep_dec   = cur.repeats - 16'd1;
    due       = cur_adv && ((cur.interval == 32'd0) || (rem1 <= 35'sd0));

    upd.fire  = due;
    upd.keep  = !(due && (cur.repeats == 16'd1));
    upd.slot  = cur;
    if (cur_adv) begin
      if (due) begin
        if (cur.repeats != 16'd0) begin
          upd.slot.repeats = rep_dec;
        end
        // A timer that has fallen a full interval behind restarts its period.
        if (rem_twice <= 35'sd0) begin
          upd.slot.remaining = {2'b00, cur.interval};
        end else begin
          upd.slot.remaining = rem_once[33:0];
        end
      end else begin
        upd.slot.remaining = rem1[33:0];
      end
    end
  end

endmodule

// File: sv/periodic_timer_table_core.sv
// Periodic timer table: start, cancel, clear and advance on a table of timers.
// Start, clear and rejected commands answer with one beat.
// Cancel and advance walk the occupied slots through one update unit, each
// slot passing through the S_SUB and S_UPD states in turn, before the first beat.
// An advance then gives one beat per fired timer (one beat if none fired); a new command is taken after.
// Reset (rst, synchronous) empties the table, sets the next handle to one.
`include "periodic_timer_table_core_macros.svh"

module periodic_timer_table_core #(
  parameter int MAX_TIMERS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  ptt_pkg::cmd_t   cmd,
  output logic            res_valid,
  input  logic            res_ready,
  output ptt_pkg::res_t   res
);

  // Slot index width and count width (a count must hold MAX_TIMERS itself).
  localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CNT_W = $clog2(MAX_TIMERS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RESP,
    S_SUB,
    S_UPD,
    S_FIN,
    S_EMIT
  } state_t;

  state_t         state;
  ptt_pkg::cmd_t  item;
  logic [CNT_W-1:0] slots_used;
  logic [31:0]    next_handle;
  logic [31:0]    fire_total;

  // Walk control: idx reads the table, w writes the compacted table back.
  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] w;
  logic [CNT_W-1:0] nfired;
  logic [CNT_W-1:0] k;
  logic             found;
  logic [1:0]       rsp_status;
  logic [31:0]      rsp_handle;

  // The slot table and the list of handles fired in the current advance.
  ptt_pkg::slot_t   slot_mem [MAX_TIMERS];
  ptt_pkg::slot_t   rd_slot;
  logic [31:0]      fire_mem [MAX_TIMERS];
  logic [31:0]      fire_rd;

  logic             cmd_fire;
  logic             res_free;
  logic             beat_load;
  logic             full;
  logic             is_cancel;
  logic             cancel_hit;
  logic [CNT_W-1:0] idx_inc;
  logic             walk_end;
  logic [CNT_W-1:0] k_inc;
  logic             emit_last;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  ptt_pkg::slot_t   mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  logic             fire_we;
  logic [IDX_W-1:0] fire_raddr;

  ptt_pkg::upd_t    upd;

  // The shared update unit sees each slot in a subtract state (S_SUB) and then
  // a decision state (S_UPD).
  ptt_slot_unit u_slot_unit (
    .clk     (clk),
    .load    (state == S_SUB),
    .advance (!is_cancel),
    .slot    (rd_slot),
    .step    (item.step_ticks),
    .upd     (upd)
  );

  always_comb begin
    cmd_ready  = (state == S_IDLE);
    cmd_fire   = cmd_valid && cmd_ready;
    res_free   = !res_valid || res_ready;
    // A new result beat is loaded into the output register this cycle.
    beat_load  = ((state == S_RESP) || (state == S_EMIT)) && res_free;
    full       = (slots_used >= CNT_W'(MAX_TIMERS));
    is_cancel  = (item.action == ptt_pkg::ACT_CANCEL);
    // Cancel removes only the first entry that carries the handle.
    cancel_hit = is_cancel && !found && (upd.slot.handle == item.cancel_handle);
    idx_inc    = CNT_W'(idx) + CNT_W'(1);
    walk_end   = (idx_inc == slots_used);
    k_inc      = k + CNT_W'(1);
    emit_last  = (k_inc == nfired);

    // A start appends at the end; a walk writes kept entries back at w.
    mem_we    = 1'b0;
    mem_waddr = w[IDX_W-1:0];
    mem_wdata = upd.slot;
    if (state == S_IDLE) begin
      mem_we    = cmd_fire && (cmd.action == ptt_pkg::ACT_START) && !full;
      mem_waddr = slots_used[IDX_W-1:0];
      mem_wdata.handle    = next_handle;
      mem_wdata.interval  = cmd.interval_ticks;
      mem_wdata.remaining = {2'b00, cmd.interval_ticks};
      mem_wdata.repeats   = cmd.repeat_count;
    end else if (state == S_UPD) begin
      mem_we = is_cancel ? !cancel_hit : upd.keep;
    end

    // The next slot is fetched while the current one is decided.
    mem_raddr = '0;
    if ((state == S_UPD) && !walk_end) begin
      mem_raddr = idx_inc[IDX_W-1:0];
    end

    fire_we    = (state == S_UPD) && upd.fire;
    fire_raddr = k[IDX_W-1:0];
    if ((state == S_EMIT) && res_free && !emit_last) begin
      fire_raddr = k_inc[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    rd_slot <= slot_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (fire_we) begin
      fire_mem[nfired[IDX_W-1:0]] <= upd.slot.handle;
    end
    fire_rd <= fire_mem[fire_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      slots_used  <= '0;
      next_handle <= 32'd1;
      fire_total  <= '0;
      res_valid   <= 1'b0;
    end else begin
      // The output register holds a beat until the sink takes it.
      if (beat_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            item       <= cmd;
            idx        <= '0;
            w          <= '0;
            nfired     <= '0;
            k          <= '0;
            found      <= 1'b0;
            case (cmd.action)
              ptt_pkg::ACT_START: begin
                if (full) begin
                  rsp_status <= ptt_pkg::ST_FULL;
                  rsp_handle <= '0;
                end else begin
                  rsp_status <= ptt_pkg::ST_OK;
                  rsp_handle <= next_handle;
                  // Handle zero is reserved, so the counter skips it on wrap.
                  next_handle <= (next_handle == 32'hFFFF_FFFF) ? 32'd1
                                                                 : next_handle + 32'd1;
                  slots_used <= slots_used + CNT_W'(1);
                end
                state <= S_RESP;
              end
              ptt_pkg::ACT_CANCEL: begin
                rsp_handle <= '0;
                if ((cmd.cancel_handle == 32'd0) || (slots_used == '0)) begin
                  rsp_status <= ptt_pkg::ST_NOT_FOUND;
                  state      <= S_RESP;
                end else begin
                  rsp_status <= ptt_pkg::ST_OK;
                  state      <= S_SUB;
                end
              end
              ptt_pkg::ACT_ADVANCE: begin
                rsp_handle <= '0;
                if (cmd.step_ticks == 32'd0) begin
                  rsp_status <= ptt_pkg::ST_ZERO_STEP;
                  state      <= S_RESP;
                end else if (slots_used == '0) begin
                  rsp_status <= ptt_pkg::ST_OK;
                  state      <= S_RESP;
                end else begin
                  rsp_status <= ptt_pkg::ST_OK;
                  state      <= S_SUB;
                end
              end
              default: begin
                // Clear keeps the handle counter and the fire total.
                rsp_status <= ptt_pkg::ST_OK;
                rsp_handle <= '0;
                slots_used <= '0;
                state      <= S_RESP;
              end
            endcase
          end
        end
        S_RESP: begin
          if (res_free) begin
            res.status        <= rsp_status;
            res.new_handle    <= rsp_handle;
            res.fired_valid   <= 1'b0;
            res.fired_handle  <= '0;
            res.fired_in_step <= '0;
            res.active_count  <= 5'(slots_used);
            res.total_fired   <= fire_total;
            res.last          <= 1'b1;
            state             <= S_IDLE;
          end
        end
        S_SUB: begin
          state <= S_UPD;
        end
        S_UPD: begin
          if (mem_we) begin
            w <= w + CNT_W'(1);
          end
          if (fire_we) begin
            nfired     <= nfired + CNT_W'(1);
            fire_total <= fire_total + 32'd1;
          end
          if (cancel_hit) begin
            found <= 1'b1;
          end
          if (walk_end) begin
            slots_used <= mem_we ? w + CNT_W'(1) : w;
            state      <= S_FIN;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_SUB;
          end
        end
        S_FIN: begin
          // The first fired handle is read out during this cycle.
          if (is_cancel) begin
            rsp_status <= found ? ptt_pkg::ST_OK : ptt_pkg::ST_NOT_FOUND;
            state      <= S_RESP;
          end else if (nfired == '0) begin
            state <= S_RESP;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (res_free) begin
            res.status        <= ptt_pkg::ST_OK;
            res.new_handle    <= '0;
            res.fired_valid   <= 1'b1;
            res.fired_handle  <= fire_rd;
            res.fired_in_step <= 5'(nfired);
            res.active_count  <= 5'(slots_used);
            res.total_fired   <= fire_total;
            res.last          <= emit_last;
            k                 <= k_inc;
            if (emit_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The compacting write pointer never overtakes the read pointer.
  `PTT_ASSERT_NOW(a_write_behind_read, state == S_UPD, w <= CNT_W'(idx))
  // No more fires than slots already visited in this walk.
  `PTT_ASSERT_NOW(a_fires_bounded, state == S_UPD, nfired <= CNT_W'(idx))
  // The table never holds more timers than it has slots.
  `PTT_ASSERT_NOW(a_table_bounded, 1'b1, slots_used <= CNT_W'(MAX_TIMERS))
  // Sending the final fired beat returns the sequencer to idle.
  `PTT_ASSERT_NEXT(a_last_ends, (state == S_EMIT) && res_free && emit_last, state == S_IDLE)

endmodule

// File: tb/sv/tb_periodic_timer_table_core.sv
`timescale 1ns / 1ps

module tb_periodic_timer_table_core;

  localparam int TBL_DEPTH = 16;
  // Slowest gap between two accepted beats: a walk of a full table, then a
  // sink stall. The limit leaves a wide margin over that.
  localparam int STALL_LIMIT = 2000;
  // Cycles allowed for stray beats after the last awaited one.
  localparam int SETTLE_CYCLES = 64;

  logic clk;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  ptt_pkg::cmd_t cmd = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  ptt_pkg::res_t res;

  periodic_timer_table_core #(
    .MAX_TIMERS(TBL_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mirror of the timer table. The queue holds the live timers in table order,
  // so its size is the active count.
  ptt_pkg::slot_t mirror_timers[$];
  logic [31:0]    mirror_next_handle = 32'd1;
  logic [31:0]    mirror_fire_total = 32'd0;

  // Result beats that the block still owes, oldest first.
  ptt_pkg::res_t awaited_beats[$];
  int   err_count = 0;

  // Idle rates in percent for the command side and the result side.
  int   sender_idle_pct = 0;
  int   sink_idle_pct = 0;
  int   ready_hold = 0;

  // Set while cmd_valid is still high for a beat that was already taken.
  bit   cmd_held = 0;

  // Applies one accepted command to the mirror and queues the beats it causes.
  function automatic void apply_timer_cmd(ptt_pkg::cmd_t c);
    ptt_pkg::res_t      r;
    ptt_pkg::slot_t     s;
    ptt_pkg::slot_t     kept[$];
    logic [31:0]        fired_ids[$];
    logic signed [33:0] rem;
    logic signed [33:0] ivl;
    bit                 keep;
    int                 idx;

    r = '0;
    r.status = ptt_pkg::ST_OK;
    r.last = 1'b1;
    case (c.action)
      ptt_pkg::ACT_START: begin
        if (mirror_timers.size() >= TBL_DEPTH) begin
          // A full table leaves the handle counter alone.
          r.status = ptt_pkg::ST_FULL;
        end else begin
          s.handle = mirror_next_handle;
          s.interval = c.interval_ticks;
          s.remaining = {2'b00, c.interval_ticks};
          s.repeats = c.repeat_count;
          mirror_timers = {mirror_timers, s};
          r.new_handle = mirror_next_handle;
          mirror_next_handle = mirror_next_handle + 32'd1;
          if (mirror_next_handle == 32'd0) mirror_next_handle = 32'd1;
        end
      end
      ptt_pkg::ACT_CANCEL: begin
        r.status = ptt_pkg::ST_NOT_FOUND;
        idx = -1;
        if (c.cancel_handle != 32'd0) begin
          foreach (mirror_timers[i]) begin
            if (idx < 0 && mirror_timers[i].handle == c.cancel_handle) idx = i;
          end
        end
        if (idx >= 0) begin
          mirror_timers.delete(idx);
          r.status = ptt_pkg::ST_OK;
        end
      end
      ptt_pkg::ACT_CLEAR: begin
        mirror_timers.delete();
      end
      default: begin
        if (c.step_ticks == 32'd0) begin
          r.status = ptt_pkg::ST_ZERO_STEP;
        end else begin
          foreach (mirror_timers[i]) begin
            s = mirror_timers[i];
            keep = 1;
            ivl = $signed({2'b00, s.interval});
            rem = s.remaining;
            rem = rem - $signed({2'b00, c.step_ticks});
            if (s.interval == 32'd0 || rem <= 0) begin
              fired_ids = {fired_ids, s.handle};
              mirror_fire_total = mirror_fire_total + 32'd1;
              if (s.repeats != 16'd0) begin
                s.repeats = s.repeats - 16'd1;
                if (s.repeats == 16'd0) keep = 0;
              end
              if (keep) begin
                // Reload by one interval; a timer that fell a whole interval
                // or more behind restarts from a full interval.
                rem = rem + ivl;
                if (rem <= -ivl) rem = ivl;
              end
            end
            s.remaining = rem;
            if (keep) kept = {kept, s};
          end
          mirror_timers = kept;
        end
      end
    endcase

    r.active_count = 5'(mirror_timers.size());
    r.total_fired = mirror_fire_total;
    if (fired_ids.size() == 0) begin
      awaited_beats = {awaited_beats, r};
    end else begin
      // One beat per fired timer, all carrying the count for the whole advance.
      foreach (fired_ids[k]) begin
        r.fired_valid = 1'b1;
        r.fired_handle = fired_ids[k];
        r.fired_in_step = 5'(fired_ids.size());
        r.last = (k == fired_ids.size() - 1);
        awaited_beats = {awaited_beats, r};
      end
    end
  endfunction

  // Command builders. Fields that the action does not use carry random values,
  // so the block is seen to ignore them.
  function automatic ptt_pkg::cmd_t any_cmd();
    ptt_pkg::cmd_t c;
    c.action = 2'($urandom_range(3, 0));
    c.interval_ticks = $urandom;
    c.repeat_count = 16'($urandom);
    c.cancel_handle = $urandom;
    c.step_ticks = $urandom;
    return c;
  endfunction

  function automatic ptt_pkg::cmd_t start_cmd(logic [31:0] ivl, logic [15:0] reps);
    ptt_pkg::cmd_t c;
    c = any_cmd();
    c.action = ptt_pkg::ACT_START;
    c.interval_ticks = ivl;
    c.repeat_count = reps;
    return c;
  endfunction

  function automatic ptt_pkg::cmd_t cancel_cmd(logic [31:0] h);
    ptt_pkg::cmd_t c;
    c = any_cmd();
    c.action = ptt_pkg::ACT_CANCEL;
    c.cancel_handle = h;
    return c;
  endfunction

  function automatic ptt_pkg::cmd_t advance_cmd(logic [31:0] step);
    ptt_pkg::cmd_t c;
    c = any_cmd();
    c.action = ptt_pkg::ACT_ADVANCE;
    c.step_ticks = step;
    return c;
  endfunction

  function automatic ptt_pkg::cmd_t clear_cmd();
    ptt_pkg::cmd_t c;
    c = any_cmd();
    c.action = ptt_pkg::ACT_CLEAR;
    return c;
  endfunction

  // Traffic mix for the random part. Most commands make sense for the current
  // table: cancels mostly name live handles and advance steps are short next
  // to the usual intervals, so timers keep firing, reloading and expiring.
  function automatic ptt_pkg::cmd_t traffic_cmd();
    int          pick;
    int          r;
    logic [31:0] ivl;
    logic [15:0] reps;
    logic [31:0] h;
    logic [31:0] step;

    pick = $urandom_range(99, 0);
    r = $urandom_range(99, 0);
    if (pick < 38) begin
      if (r < 10) ivl = 32'd0;
      else if (r < 85) ivl = $urandom_range(12, 1);
      else ivl = $urandom;
      r = $urandom_range(99, 0);
      if (r < 40) reps = 16'd0;
      else if (r < 90) reps = 16'($urandom_range(4, 1));
      else reps = 16'($urandom);
      return start_cmd(ivl, reps);
    end else if (pick < 56) begin
      if (r < 70 && mirror_timers.size() != 0)
        h = mirror_timers[$urandom_range(mirror_timers.size() - 1, 0)].handle;
      else if (r < 80) h = 32'd0;
      else if (r < 90) h = mirror_next_handle;
      else h = $urandom;
      return cancel_cmd(h);
    end else if (pick < 92) begin
      if (r < 5) step = 32'd0;
      else if (r < 90) step = $urandom_range(10, 1);
      else if (r < 96) step = $urandom;
      else step = 32'hFFFF_FFFF;
      return advance_cmd(step);
    end else if (pick < 96) begin
      return clear_cmd();
    end
    return any_cmd();
  endfunction

  // Offers one command beat and returns in the time step in which it was taken.
  // cmd_valid stays high after that, so a following call in the same step can
  // put the next beat straight behind it.
  task automatic send_cmd(input ptt_pkg::cmd_t c);
    int gap;
    if (sender_idle_pct != 0 && $urandom_range(99, 0) < sender_idle_pct) begin
      gap = $urandom_range(4, 1);
      if (cmd_held) cmd_valid <= 1'b0;
      cmd_held = 0;
      repeat (gap) @(posedge clk);
    end
    cmd <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (!cmd_ready);
    apply_timer_cmd(c);
    cmd_held = 1;
  endtask

  // Takes the command valid down and waits until every awaited beat is in.
  task automatic wait_until_drained();
    if (cmd_held) cmd_valid <= 1'b0;
    cmd_held = 0;
    while (awaited_beats.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_count++;
    end
  endtask

  // Result side: checks each accepted beat against the oldest awaited one and
  // then picks the ready level for the next cycle. Stalls come in bursts that
  // ready_hold counts down.
  always @(posedge clk) begin : beat_checker
    ptt_pkg::res_t want;
    if (!rst && res_valid && res_ready) begin
      if (awaited_beats.size() == 0) begin
        $error("result beat with nothing awaited: %p", res);
        err_count++;
      end else begin
        want = awaited_beats.pop_front();
        check_field("status", 32'(want.status), 32'(res.status));
        check_field("new_handle", want.new_handle, res.new_handle);
        check_field("fired_valid", 32'(want.fired_valid), 32'(res.fired_valid));
        check_field("fired_handle", want.fired_handle, res.fired_handle);
        check_field("fired_in_step", 32'(want.fired_in_step), 32'(res.fired_in_step));
        check_field("active_count", 32'(want.active_count), 32'(res.active_count));
        check_field("total_fired", want.total_fired, res.total_fired);
        check_field("last", 32'(want.last), 32'(res.last));
      end
    end
    if (ready_hold != 0) begin
      ready_hold--;
      res_ready <= 1'b0;
    end else if (sink_idle_pct != 0 && $urandom_range(99, 0) < sink_idle_pct) begin
      ready_hold = $urandom_range(3, 0);
      res_ready <= 1'b0;
    end else begin
      res_ready <= 1'b1;
    end
  end

  // An empty table: advancing, cancelling and clearing must all be harmless.
  task automatic test_empty_table();
    sender_idle_pct = 25;
    sink_idle_pct = 25;
    send_cmd(advance_cmd(32'd1));
    send_cmd(cancel_cmd(32'd1));
    send_cmd(clear_cmd());
  endtask

  // Fills the table with extreme intervals and repeat counts, overfills it,
  // then fires everything, including the restart of timers that fell a whole
  // interval behind, and ends with the error statuses, a clear and a start.
  task automatic test_fill_and_fire();
    send_cmd(start_cmd(32'd0, 16'd1));
    send_cmd(start_cmd(32'd0, 16'd0));
    send_cmd(start_cmd(32'd1, 16'd0));
    send_cmd(start_cmd(32'hFFFF_FFFF, 16'hFFFF));
    send_cmd(start_cmd(32'hFFFF_FFFF, 16'd1));
    send_cmd(start_cmd(32'd5, 16'd2));
    send_cmd(start_cmd(32'd3, 16'd3));
    send_cmd(start_cmd(32'd7, 16'd0));
    send_cmd(start_cmd(32'd2, 16'd1));
    send_cmd(start_cmd(32'd10, 16'h8000));
    send_cmd(start_cmd(32'd1, 16'hFFFF));
    send_cmd(start_cmd(32'h8000_0000, 16'd0));
    send_cmd(start_cmd(32'd4, 16'd1));
    send_cmd(start_cmd(32'd6, 16'd2));
    send_cmd(start_cmd(32'd9, 16'd0));
    send_cmd(start_cmd(32'd11, 16'd1));
    // The table is full now, so this start is refused.
    send_cmd(start_cmd(32'd8, 16'd1));
    // Hold the sender back until the block has answered everything.
    wait_until_drained();
    send_cmd(advance_cmd(32'd1));
    send_cmd(advance_cmd(32'hFFFF_FFFF));
    send_cmd(cancel_cmd(mirror_timers.size() != 0 ? mirror_timers[0].handle : 32'd1));
    send_cmd(cancel_cmd(32'd0));
    send_cmd(cancel_cmd(32'hFFFF_FFFF));
    send_cmd(advance_cmd(32'd0));
    send_cmd(clear_cmd());
    // Handles keep counting across a clear.
    send_cmd(start_cmd(32'd3, 16'd0));
  endtask

  // Random traffic, with stretches where either side idles and stretches
  // where neither does.
  task automatic test_random_traffic();
    int n;
    for (n = 0; n < 333; n++) begin
      if (n % 50 == 0) begin
        sender_idle_pct = $urandom_range(1, 0) ? 30 : 0;
        sink_idle_pct = $urandom_range(1, 0) ? 30 : 0;
      end
      if (n == 166) wait_until_drained();
      send_cmd(traffic_cmd());
    end
  endtask

  // Back to back traffic with no idling at all.
  task automatic test_steady_stream();
    int n;
    sender_idle_pct = 0;
    sink_idle_pct = 0;
    for (n = 0; n < 60; n++) send_cmd(traffic_cmd());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_fill_and_fire();
    test_random_traffic();
    test_steady_stream();
    wait_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_periodic_timer_table_core: clean");
    end else begin
      $display("tb_periodic_timer_table_core: errors");
    end
    $finish;
  end

  // Ends a run in which no beat moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) quiet = 0;
      else quiet++;
    end
    $display("tb_periodic_timer_table_core: errors");
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/ptt_pkg.sv
sv/ptt_slot_unit.sv
sv/periodic_timer_table_core.sv
tb/sv/tb_periodic_timer_table_core.sv
